// ===== rtl/core/pcd_pkg.sv =====
package pcd_pkg;

  localparam int MAX_NODES   = 32;
  localparam int IDX_W       = $clog2(MAX_NODES);
  localparam int LEN_W       = $clog2(MAX_NODES + 1);
  localparam int CFG_W       = 6;
  localparam int ROW_CNT_W   = 6;
  localparam int NODE_W      = 6;
  localparam int JOB_Q_DEPTH = 2;

  localparam logic [CFG_W-1:0]     NODE_COUNT_RESET = 6'd32;
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX      = '1;

  typedef logic [MAX_NODES-1:0] node_vec_t;

  // one matrix handed from the row loader to the decomposer
  typedef struct packed {
    logic bank;
    logic pre_fault;
  } job_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } job_done_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FIND,
    B_WALK,
    B_NEXT_LEN,
    B_PICK,
    B_NODE,
    B_CLOSE,
    B_FAULT
  } b_state_t;

  function automatic logic [IDX_W-1:0] lowest_set(input node_vec_t v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  // zero acts as one node, anything above the table size as the table size
  function automatic logic [CFG_W-1:0] nodes_in_use(input logic [CFG_W-1:0] cnt);
    logic [CFG_W-1:0] r;
    r = cnt;
    if (cnt == '0) r = CFG_W'(1);
    else if (cnt > CFG_W'(MAX_NODES)) r = CFG_W'(MAX_NODES);
    return r;
  endfunction

  function automatic node_vec_t node_mask_of(input logic [CFG_W-1:0] n);
    node_vec_t m;
    for (int i = 0; i < MAX_NODES; i++) begin
      m[i] = (CFG_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/pcd_front.sv =====
module pcd_front
  import pcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 row_valid,
  output logic                 row_ready,
  input  logic [31:0]          row_mask,
  input  logic                 last_row,
  input  logic [CFG_W-1:0]     node_num,
  input  node_vec_t            node_mask,
  input  job_done_t            done,
  input  logic                 q_full,
  output tbl_wr_t              wr,
  output logic                 push,
  output job_t                 push_job
);

  logic [ROW_CNT_W-1:0] row_counter;
  logic                 row_fault;
  logic                 wr_bank;
  logic [1:0]           bank_busy;
  logic [1:0]           bank_busy_next;

  logic                 accept;
  node_vec_t            masked;
  logic                 found;
  logic [IDX_W-1:0]     succ;
  logic [ROW_CNT_W-1:0] rc_inc;

  assign row_ready = !bank_busy[wr_bank] && !q_full;
  assign accept    = row_valid && row_ready;

  assign masked = row_mask[MAX_NODES-1:0] & node_mask;
  assign found  = |masked;
  assign succ   = lowest_set(masked);
  assign rc_inc = (row_counter == ROW_CNT_MAX) ? row_counter : row_counter + ROW_CNT_W'(1);

  // rows beyond the table are counted but not stored
  assign wr.en   = accept && (row_counter < ROW_CNT_W'(MAX_NODES));
  assign wr.bank = wr_bank;
  assign wr.addr = row_counter[IDX_W-1:0];
  assign wr.data = succ;

  assign push               = accept && last_row;
  assign push_job.bank      = wr_bank;
  assign push_job.pre_fault = row_fault || !found || (rc_inc != ROW_CNT_W'(node_num));

  always_comb begin
    bank_busy_next = bank_busy;
    if (done.valid) bank_busy_next[done.bank] = 1'b0;
    if (push) bank_busy_next[wr_bank] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      row_fault   <= 1'b0;
      wr_bank     <= 1'b0;
      bank_busy   <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      if (accept) begin
        if (last_row) begin
          row_counter <= '0;
          row_fault   <= 1'b0;
          wr_bank     <= !wr_bank;
        end else begin
          row_counter <= rc_inc;
          if (!found) row_fault <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/pcd_job_fifo.sv =====
module pcd_job_fifo
  import pcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PTR_W = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

  job_t             entries [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(JOB_Q_DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= ptr_inc(wptr);
      if (do_pop) rptr <= ptr_inc(rptr);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/pcd_back.sv =====
module pcd_back
  import pcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  node_vec_t         node_mask,
  input  tbl_wr_t           wr,
  input  job_t              job,
  input  logic              q_empty,
  output logic              pop,
  output job_done_t         done,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [NODE_W-1:0] node,
  output logic              cycle_end,
  output logic              last,
  output logic              fault
);

  logic [IDX_W-1:0] tbl0 [MAX_NODES];
  logic [IDX_W-1:0] tbl1 [MAX_NODES];

  b_state_t state;
  b_state_t state_next;

  logic             job_bank;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] start;
  logic [LEN_W-1:0] wlen;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] remain;
  node_vec_t        visited;
  node_vec_t        is_start;
  node_vec_t        len_present;
  node_vec_t        match;
  logic [LEN_W-1:0] len_of [MAX_NODES];

  logic [IDX_W-1:0] succ_cur;
  logic             slot_free;
  node_vec_t        cand;
  logic             cand_any;
  logic [IDX_W-1:0] cand_idx;
  logic [LEN_W-1:0] wlen_inc;
  logic             walk_close;
  logic [IDX_W-1:0] len_idx;
  logic [LEN_W-1:0] len_new;
  node_vec_t        match_new;
  logic [IDX_W-1:0] match_idx;
  node_vec_t        match_rest;
  logic             all_out;

  logic              out_load;
  logic [NODE_W-1:0] out_node;
  logic              out_end;
  logic              out_last;
  logic              out_fault;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.bank) tbl1[wr.addr] <= wr.data;
      else tbl0[wr.addr] <= wr.data;
    end
  end

  assign succ_cur   = job_bank ? tbl1[cur] : tbl0[cur];
  assign slot_free  = !res_valid || res_ready;
  assign cand       = ~visited & node_mask;
  assign cand_any   = |cand;
  assign cand_idx   = lowest_set(cand);
  assign wlen_inc   = wlen + LEN_W'(1);
  assign walk_close = (succ_cur == start);
  assign len_idx    = lowest_set(len_present);
  assign len_new    = LEN_W'(len_idx) + LEN_W'(1);
  assign match_idx  = lowest_set(match);
  assign match_rest = match & ~(node_vec_t'(1) << start);
  assign all_out    = (match_rest == '0) && (len_present == '0);

  always_comb begin
    for (int s = 0; s < MAX_NODES; s++) begin
      match_new[s] = is_start[s] && (len_of[s] == len_new);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (!q_empty) state_next = job.pre_fault ? B_FAULT : B_FIND;
      B_FIND:     state_next = cand_any ? B_WALK : B_NEXT_LEN;
      B_WALK: begin
        if (visited[cur]) state_next = B_FAULT;
        else if (walk_close) state_next = B_FIND;
      end
      B_NEXT_LEN: state_next = B_PICK;
      B_PICK:     state_next = B_NODE;
      B_NODE:     if (slot_free && remain == LEN_W'(1)) state_next = B_CLOSE;
      B_CLOSE: begin
        if (slot_free) begin
          priority if (match_rest != '0) state_next = B_PICK;
          else if (len_present != '0) state_next = B_NEXT_LEN;
          else state_next = B_IDLE;
        end
      end
      B_FAULT:    if (slot_free) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    done.valid = 1'b0;
    done.bank  = job_bank;
    out_load   = 1'b0;
    out_node   = NODE_W'(cur) + NODE_W'(1);
    out_end    = 1'b0;
    out_last   = 1'b0;
    out_fault  = 1'b0;
    unique case (state)
      B_IDLE: pop = !q_empty;
      B_NODE: out_load = slot_free;
      B_CLOSE: begin
        out_load   = slot_free;
        out_node   = NODE_W'(start) + NODE_W'(1);
        out_end    = 1'b1;
        out_last   = all_out;
        done.valid = slot_free && all_out;
      end
      B_FAULT: begin
        out_load   = slot_free;
        out_node   = '0;
        out_last   = 1'b1;
        out_fault  = 1'b1;
        done.valid = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          job_bank    <= job.bank;
          visited     <= '0;
          is_start    <= '0;
          len_present <= '0;
        end
      end
      B_FIND: begin
        if (cand_any) begin
          start <= cand_idx;
          cur   <= cand_idx;
          wlen  <= '0;
        end
      end
      B_WALK: begin
        if (!visited[cur]) begin
          visited[cur] <= 1'b1;
          if (walk_close) begin
            // length minus one is the walk count before this step
            is_start[start]               <= 1'b1;
            len_of[start]                 <= wlen_inc;
            len_present[wlen[IDX_W-1:0]]  <= 1'b1;
          end else begin
            cur  <= succ_cur;
            wlen <= wlen_inc;
          end
        end
      end
      B_NEXT_LEN: begin
        cur_len              <= len_new;
        len_present[len_idx] <= 1'b0;
        match                <= match_new;
      end
      B_PICK: begin
        start  <= match_idx;
        cur    <= match_idx;
        remain <= cur_len;
      end
      B_NODE: begin
        if (slot_free) begin
          cur    <= succ_cur;
          remain <= remain - LEN_W'(1);
        end
      end
      B_CLOSE: if (slot_free) match <= match_rest;
      default: ;
    endcase
  end

  // output register: hold until transfer, reload in the same cycle
  always_ff @(posedge clk) begin
    if (out_load) begin
      node      <= out_node;
      cycle_end <= out_end;
      last      <= out_last;
      fault     <= out_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (out_load) res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end

endmodule

// ===== rtl/core/permutation_cycle_decomposer.sv =====
// Takes an assignment matrix one row per transfer (lowest set bit of each row
// names that node's successor; tlast marks the final row) and returns its
// cycles, shortest first and equal lengths by smallest start node, each as
// 1-based node numbers from its start node plus a closing repeat of the start
// node flagged in tuser bit 0. A bad matrix (empty row, wrong row count, or
// not a permutation) returns one result with node 0 and the fault flag.
// Rows load at one per cycle while row_ready is high (the target bank is
// free and the job queue is not full) into one of two successor banks, so
// the next matrix can load while the current one is being decomposed.
// Decomposing a matrix takes the job, then walks each node, searching for an
// unvisited start node before each walk and when none is left, then sets
// up each distinct length in turn and per cycle picks its start, emits one
// result per node and the closing result. Each result waits for
// the output register to be free, so a stalled receiver holds the emission.
// The walk and emission share one successor read port.
module permutation_cycle_decomposer
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,    // node_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // row_mask
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // node[5:0], zero fill
  output logic [1:0]  m_tuser,     // {fault, cycle_end}
  output logic        m_tlast
);

  logic [CFG_W-1:0]  node_count;
  logic [CFG_W-1:0]  node_num;
  node_vec_t         node_mask;

  tbl_wr_t           wr;
  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  job_t              head;
  job_done_t         done;
  logic [NODE_W-1:0] node;
  logic              cycle_end;
  logic              fault;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) node_count <= NODE_COUNT_RESET;
    else if (cfg_valid && cfg_ready) node_count <= cfg_data;
  end

  assign node_num  = nodes_in_use(node_count);
  assign node_mask = node_mask_of(node_num);

  pcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .row_valid (s_tvalid),
    .row_ready (s_tready),
    .row_mask  (s_tdata),
    .last_row  (s_tlast),
    .node_num  (node_num),
    .node_mask (node_mask),
    .done      (done),
    .q_full    (q_full),
    .wr        (wr),
    .push      (push),
    .push_job  (push_job)
  );

  pcd_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  pcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .node_mask (node_mask),
    .wr        (wr),
    .job       (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .done      (done),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .node      (node),
    .cycle_end (cycle_end),
    .last      (m_tlast),
    .fault     (fault)
  );

  assign m_tdata = {{(8 - NODE_W){1'b0}}, node};
  assign m_tuser = {fault, cycle_end};

endmodule
